// ----- src/ats_pkg.sv -----
// ============================================================================
// ats_pkg
// Shared types, token codes, word table and character-class helpers for the
// assembly token scanner.
// ============================================================================
package ats_pkg;

    localparam int NUM_WORDS = 10;
    localparam int WORD_MAX  = 11;

    // Token type codes
    localparam logic [3:0] TT_INVALID  = 4'd0;
    localparam logic [3:0] TT_LBRACE   = 4'd1;
    localparam logic [3:0] TT_RBRACE   = 4'd2;
    localparam logic [3:0] TT_INTEGER  = 4'd3;
    localparam logic [3:0] TT_LABELDEF = 4'd4;
    localparam logic [3:0] TT_LABELREF = 4'd5;

    // Result kinds
    localparam logic RK_ECHO   = 1'b0;
    localparam logic RK_RECORD = 1'b1;

    // Character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_COLON  = 8'h3A;

    // Word table: entries 0..7 are opcodes, 8 and 9 are keywords.
    // Text is right-justified, first character in the highest used byte.
    localparam logic [8*WORD_MAX-1:0] WORD_STR [NUM_WORDS] = '{
        88'("nop"), 88'("halt"), 88'("jump"), 88'("jump-unless"),
        88'("global-ref"), 88'("global-set"), 88'("load-i16"), 88'("call"),
        88'("procedure"), 88'("fixnum32")
    };
    localparam logic [3:0] WORD_LEN [NUM_WORDS] = '{
        4'd3, 4'd4, 4'd4, 4'd11, 4'd10, 4'd10, 4'd8, 4'd4, 4'd9, 4'd8
    };
    localparam logic [3:0] WORD_TYPE [NUM_WORDS] = '{
        4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15, 4'd7, 4'd6
    };

    typedef logic [NUM_WORDS-1:0] t_flags;
    localparam t_flags ALL_FLAGS = '1;

    typedef struct packed {
        logic        result_kind;
        logic [3:0]  token_code;
        logic [15:0] token_line;
        logic [15:0] token_column;
        logic [7:0]  text_char;
        logic [7:0]  text_length;
        logic        overflow;
    } t_result;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
    endfunction

    function automatic logic is_decimal(input logic [7:0] c);
        return c >= 8'd48 && c <= 8'd57;
    endfunction

    function automatic logic is_ident(input logic [7:0] c);
        return is_alpha(c) || is_decimal(c) || (c == CH_MINUS);
    endfunction

    // Clear the flag of every word whose character at idx is not c.
    function automatic t_flags match_flags(input t_flags f, input logic [7:0] idx,
                                           input logic [7:0] c);
        t_flags     r;
        logic [3:0] off;
        r = f;
        for (int i = 0; i < NUM_WORDS; i++) begin
            off = (WORD_LEN[i] - 4'd1) - idx[3:0];
            if (idx >= {4'd0, WORD_LEN[i]}) begin
                r[i] = 1'b0;
            end else if (WORD_STR[i][{off, 3'b000} +: 8] != c) begin
                r[i] = 1'b0;
            end
        end
        return r;
    endfunction

    // First still-matching word in [first, last] of the right length.
    function automatic logic [3:0] lookup_word(input t_flags f, input logic [7:0] wl,
                                               input int first, input int last);
        logic [3:0] t;
        logic       found;
        t = TT_INVALID;
        found = 1'b0;
        for (int i = 0; i < NUM_WORDS; i++) begin
            if (!found && i >= first && i <= last && f[i] &&
                {4'd0, WORD_LEN[i]} == wl) begin
                t = WORD_TYPE[i];
                found = 1'b1;
            end
        end
        return t;
    endfunction

endpackage

// ----- src/ats_if.sv -----
// ============================================================================
// ats_if
// Valid/ready channels of the assembly token scanner: source characters in,
// token results out.
// ============================================================================
interface ats_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       end_of_input;

    modport source (output valid, output char_in, output end_of_input, input ready);
    modport sink   (input valid, input char_in, input end_of_input, output ready);
endinterface

interface ats_token_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [3:0]  token_code;
    logic [15:0] token_line;
    logic [15:0] token_column;
    logic [7:0]  text_char;
    logic [7:0]  text_length;
    logic        overflow;

    modport source (output valid, output result_kind, output token_code,
                    output token_line, output token_column, output text_char,
                    output text_length, output overflow, input ready);
    modport sink   (input valid, input result_kind, input token_code,
                    input token_line, input token_column, input text_char,
                    input text_length, input overflow, output ready);
endinterface

// ----- src/ats_scan.sv -----
// ============================================================================
// ats_scan
// Scanner state and per-character transition. Gives up to two results for
// each character taken.
// ============================================================================
module ats_scan #(
    parameter int MAX_TOKEN_LEN = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [7:0]        i_char,
    input  logic              i_end,
    output logic [1:0]        o_count,
    output ats_pkg::t_result  o_res0,
    output ats_pkg::t_result  o_res1
);
    import ats_pkg::*;

    typedef enum logic [3:0] {
        M_IDLE, M_LBRACE, M_RBRACE, M_IDENT, M_COLON, M_KEYWORD, M_LABELREF, M_INTEGER
    } t_mode;

    localparam logic [7:0] MAX_LEN = 8'(MAX_TOKEN_LEN);

    t_mode       r_mode,       n_mode;
    logic [7:0]  r_word_len,   n_word_len;
    t_flags      r_flags,      n_flags;
    logic [15:0] r_cur_line,   n_cur_line;
    logic [15:0] r_cur_col,    n_cur_col;
    logic [15:0] r_start_line, n_start_line;
    logic [15:0] r_start_col,  n_start_col;

    logic    eoi, stop, ok;
    // start-of-token outcome for the current character
    t_mode   s_mode;
    logic    s_emit;
    logic    s_copy;
    t_result s_res;
    // first result (record or continuing echo) and whether a start follows
    logic    f_valid;
    t_result f_res;
    logic    do_start;

    always_comb begin
        eoi  = i_end || (i_char == CH_NUL);
        stop = eoi || is_space(i_char);

        // token start from this character
        s_emit = 1'b0;
        s_copy = 1'b0;
        s_mode = M_IDLE;
        s_res  = '0;
        s_res.token_line   = r_cur_line;
        s_res.token_column = r_cur_col;
        if (is_space(i_char)) begin
            s_mode = M_IDLE;
        end else if (i_char == CH_LBRACE) begin
            s_mode = M_LBRACE;
        end else if (i_char == CH_RBRACE) begin
            s_mode = M_RBRACE;
        end else if (i_char == CH_DOT) begin
            s_mode = M_KEYWORD;
        end else if (i_char == CH_AT) begin
            s_mode = M_LABELREF;
        end else if (is_alpha(i_char)) begin
            s_mode = M_IDENT;
            s_copy = 1'b1;
        end else if (is_decimal(i_char) || i_char == CH_PLUS || i_char == CH_MINUS) begin
            s_mode = M_INTEGER;
            s_copy = 1'b1;
        end else begin
            s_emit = 1'b1;  // unknown start: invalid record, length 0
            s_res.result_kind = RK_RECORD;
            s_res.token_code  = TT_INVALID;
        end
        if (s_copy) begin
            s_emit = 1'b1;
            s_res.result_kind = RK_ECHO;
            s_res.text_char   = i_char;
        end

        // first result
        f_valid  = 1'b0;
        do_start = 1'b0;
        f_res    = '0;
        f_res.result_kind  = RK_RECORD;
        f_res.token_line   = r_start_line;
        f_res.token_column = r_start_col;
        f_res.text_length  = r_word_len;

        n_mode     = r_mode;
        n_word_len = r_word_len;
        n_flags    = r_flags;
        ok         = 1'b0;

        case (r_mode)
            M_IDLE: begin
                do_start = !eoi;
            end
            M_LBRACE, M_RBRACE: begin
                f_valid = 1'b1;
                f_res.text_length = 8'd0;
                if (stop) begin
                    f_res.token_code = (r_mode == M_LBRACE) ? TT_LBRACE : TT_RBRACE;
                    n_mode = M_IDLE;
                end else begin
                    f_res.token_code = TT_INVALID;
                    do_start = 1'b1;
                end
            end
            M_IDENT, M_KEYWORD, M_LABELREF, M_INTEGER: begin
                ok = !eoi && ((r_mode == M_INTEGER) ? is_decimal(i_char) : is_ident(i_char));
                if (ok) begin
                    f_valid = 1'b1;
                    if (r_word_len >= MAX_LEN) begin
                        f_res.token_code = TT_INVALID;
                        f_res.overflow   = 1'b1;
                        do_start = 1'b1;
                    end else begin
                        f_res.result_kind = RK_ECHO;
                        f_res.text_char   = i_char;
                        f_res.text_length = 8'd0;
                        n_flags    = match_flags(r_flags, r_word_len, i_char);
                        n_word_len = r_word_len + 8'd1;
                    end
                end else if (stop) begin
                    f_valid = 1'b1;
                    case (r_mode)
                        M_IDENT:    f_res.token_code = lookup_word(r_flags, r_word_len, 0, 7);
                        M_KEYWORD:  f_res.token_code = lookup_word(r_flags, r_word_len, 8, 9);
                        M_LABELREF: f_res.token_code = TT_LABELREF;
                        default:    f_res.token_code = TT_INTEGER;
                    endcase
                    n_mode = M_IDLE;
                end else if (r_mode == M_IDENT && i_char == CH_COLON) begin
                    n_mode = M_COLON;
                end else begin
                    f_valid = 1'b1;
                    f_res.token_code = TT_INVALID;
                    do_start = 1'b1;
                end
            end
            M_COLON: begin
                f_valid = 1'b1;
                if (stop) begin
                    f_res.token_code = TT_LABELDEF;
                    n_mode = M_IDLE;
                end else begin
                    f_res.token_code = TT_INVALID;
                    do_start = 1'b1;
                end
            end
            default: begin
                n_mode   = M_IDLE;
                do_start = !eoi;
            end
        endcase

        n_start_line = r_start_line;
        n_start_col  = r_start_col;
        if (do_start) begin
            n_mode = s_mode;
            if (!is_space(i_char)) begin
                n_start_line = r_cur_line;
                n_start_col  = r_cur_col;
                n_word_len   = s_copy ? 8'd1 : 8'd0;
                n_flags      = s_copy ? match_flags(ALL_FLAGS, 8'd0, i_char) : ALL_FLAGS;
            end
        end

        // result ordering
        if (f_valid) begin
            o_res0  = f_res;
            o_res1  = s_res;
            o_count = (do_start && s_emit) ? 2'd2 : 2'd1;
        end else begin
            o_res0  = s_res;
            o_res1  = s_res;
            o_count = (do_start && s_emit) ? 2'd1 : 2'd0;
        end

        // position tracking, saturating
        n_cur_line = r_cur_line;
        n_cur_col  = r_cur_col;
        if (!eoi) begin
            if (i_char == CH_LF) begin
                if (r_cur_line != 16'hFFFF) n_cur_line = r_cur_line + 16'd1;
                n_cur_col = 16'd1;
            end else if (r_cur_col != 16'hFFFF) begin
                n_cur_col = r_cur_col + 16'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= M_IDLE;
            r_word_len   <= 8'd0;
            r_flags      <= ALL_FLAGS;
            r_cur_line   <= 16'd1;
            r_cur_col    <= 16'd1;
            r_start_line <= 16'd1;
            r_start_col  <= 16'd1;
        end else if (i_fire) begin
            r_mode       <= n_mode;
            r_word_len   <= n_word_len;
            r_flags      <= n_flags;
            r_cur_line   <= n_cur_line;
            r_cur_col    <= n_cur_col;
            r_start_line <= n_start_line;
            r_start_col  <= n_start_col;
        end
    end

endmodule

// ----- src/ats_result_fifo.sv -----
// ============================================================================
// ats_result_fifo
// Four-entry result queue: takes up to two results a cycle, gives one.
// ============================================================================
module ats_result_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_push,
    input  ats_pkg::t_result  i_res0,
    input  ats_pkg::t_result  i_res1,
    input  logic              i_pop,
    output logic              o_valid,
    output ats_pkg::t_result  o_res,
    output logic              o_room
);
    import ats_pkg::*;

    t_result    r_mem [4];
    logic [1:0] r_wr_ptr, n_wr_ptr;
    logic [1:0] r_rd_ptr, n_rd_ptr;
    logic [2:0] r_count,  n_count;
    logic       pop_ok;

    assign o_valid = (r_count != 3'd0);
    assign o_res   = r_mem[r_rd_ptr];
    assign o_room  = (r_count <= 3'd2);   // room for two regardless of pop
    assign pop_ok  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr + i_push;
        n_rd_ptr = r_rd_ptr + {1'b0, pop_ok};
        n_count  = r_count + {1'b0, i_push} - {2'b00, pop_ok};
    end

    always_ff @(posedge i_clk) begin
        if (i_push != 2'd0) r_mem[r_wr_ptr] <= i_res0;
        if (i_push == 2'd2) r_mem[r_wr_ptr + 2'd1] <= i_res1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_count  <= 3'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ----- src/assembly_token_scanner.sv -----
// ============================================================================
// assembly_token_scanner
// Groups a character stream into assembly-language tokens, echoing each
// copied text character and emitting a record per completed token.
// ============================================================================
// Takes one source character per cycle on i_char and returns results on
// o_token in order: an echo (result_kind 0) for each copied text character,
// and a record (result_kind 1) with type, start line/column, length and
// overflow when a token closes. A character lands in an input register, is
// scanned once the queue has room for two results, and its results enter a
// four-entry result queue at the end of that cycle; the queue head is offered
// on o_token. A character that closes one token and starts another gives two
// results, which the output gives one after the other; the input keeps taking
// one character per cycle as long as the queue holds no more than two
// results. end_of_input, or a NUL character, closes a pending token without
// moving the position.
// MAX_TOKEN_LEN (128..255) caps the copied length; one more acceptable
// character gives an invalid record with overflow set.
module assembly_token_scanner #(
    parameter int MAX_TOKEN_LEN = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ats_char_if.sink    i_char,
    ats_token_if.source o_token
);
    import ats_pkg::*;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_end;

    logic       fire;
    logic       room;
    logic [1:0] push;
    t_result    res0, res1, head;
    logic       head_valid;

    // scan the held character once the queue can take both possible results
    assign fire         = r_in_valid && room;
    assign i_char.ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_char.ready) begin
            r_in_valid <= i_char.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.valid && i_char.ready) begin
            r_in_char <= i_char.char_in;
            r_in_end  <= i_char.end_of_input;
        end
    end

    ats_scan #(
        .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_char  (r_in_char),
        .i_end   (r_in_end),
        .o_count (push),
        .o_res0  (res0),
        .o_res1  (res1)
    );

    ats_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire ? push : 2'd0),
        .i_res0  (res0),
        .i_res1  (res1),
        .i_pop   (o_token.ready),
        .o_valid (head_valid),
        .o_res   (head),
        .o_room  (room)
    );

    assign o_token.valid        = head_valid;
    assign o_token.result_kind  = head.result_kind;
    assign o_token.token_code   = head.token_code;
    assign o_token.token_line   = head.token_line;
    assign o_token.token_column = head.token_column;
    assign o_token.text_char    = head.text_char;
    assign o_token.text_length  = head.text_length;
    assign o_token.overflow     = head.overflow;

endmodule
